### rtl/jesl_pkg.sv
// Shared types, marker codes and helper functions for the JPEG Exif segment locator.
// Used by jesl_parser, jpeg_exif_segment_locator and jesl_checker; no dependencies.

package jesl_pkg;

  localparam logic [15:0] MK_SOI    = 16'hFFD8;
  localparam logic [15:0] MK_EOI    = 16'hFFD9;
  localparam logic [15:0] MK_SOS    = 16'hFFDA;
  localparam logic [15:0] MK_APP1   = 16'hFFE1;
  localparam logic [15:0] MK_APP0   = 16'hFFE0;
  localparam logic [15:0] MK_APP15  = 16'hFFEF;
  localparam logic [15:0] MK_COM    = 16'hFFFE;
  localparam logic [15:0] MK_DQT    = 16'hFFDB;
  localparam logic [15:0] MK_DRI    = 16'hFFDD;
  localparam logic [15:0] MK_SOF0   = 16'hFFC0;
  localparam logic [15:0] MK_SOF2   = 16'hFFC2;
  localparam logic [15:0] MK_DHT    = 16'hFFC4;
  localparam logic [15:0] MIN_LEN   = 16'd2;

  typedef enum logic [3:0] {
    PH_SOI_HI = 4'd0,
    PH_SOI_LO = 4'd1,
    PH_MK_HI  = 4'd2,
    PH_MK_LO  = 4'd3,
    PH_LEN_HI = 4'd4,
    PH_LEN_LO = 4'd5,
    PH_SKIP   = 4'd6,
    PH_SIG    = 4'd7,
    PH_DONE   = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_TRUNCATED = 3'd1,
    ST_NO_SOI    = 3'd2,
    ST_BAD_SEG   = 3'd3,
    ST_END_IMAGE = 3'd4,
    ST_UNSUP     = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] segment_offset;
    logic [16:0] segment_size;
  } out_item_t;

  function automatic logic skippable(input logic [15:0] m);
    logic hit;
    hit = (m >= MK_APP0 && m <= MK_APP15) || (m == MK_COM) ||
          (m >= MK_DQT && m <= MK_DRI) ||
          (m == MK_SOF0) || (m == MK_SOF2) || (m == MK_DHT);
    return hit;
  endfunction

  function automatic logic [7:0] exif_sig_byte(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0: v = 8'h45;
      2'd1: v = 8'h78;
      2'd2: v = 8'h69;
      default: v = 8'h66;
    endcase
    return v;
  endfunction

endpackage

### rtl/jesl_parser.sv
// Byte-wise marker segment parser: holds the parse state and forms at most one result per image.
// Depends on jesl_pkg.

module jesl_parser
  import jesl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  in_item_t  item,
  output logic      res_valid,
  output out_item_t res
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] marker_r, marker_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [1:0]  sig_idx_r, sig_idx_nxt;
  logic        sig_match_r, sig_match_nxt;
  logic [31:0] byte_pos_r, byte_pos_nxt;
  logic [31:0] marker_pos_r, marker_pos_nxt;

  logic [7:0]  b;
  logic [15:0] code;
  logic [15:0] len_full;
  logic        hit;
  logic        match;
  status_t     st;

  always_comb begin
    b              = item.data_byte;
    code           = {marker_r[7:0], b};
    len_full       = {len_r[15:8], b};
    match          = sig_match_r && (b == exif_sig_byte(sig_idx_r));
    phase_nxt      = phase_r;
    marker_nxt     = marker_r;
    len_nxt        = len_r;
    skip_nxt       = skip_r;
    sig_idx_nxt    = sig_idx_r;
    sig_match_nxt  = sig_match_r;
    byte_pos_nxt   = byte_pos_r + 32'd1;
    marker_pos_nxt = marker_pos_r;
    hit            = 1'b0;
    st             = ST_TRUNCATED;
    res_valid      = 1'b0;
    res            = '0;

    case (phase_r)
      PH_SOI_HI: begin
        marker_nxt = {8'h00, b};
        phase_nxt  = PH_SOI_LO;
      end
      PH_SOI_LO: begin
        marker_nxt = code;
        if (code != MK_SOI) begin
          hit = 1'b1;
          st  = ST_NO_SOI;
        end else begin
          phase_nxt = PH_MK_HI;
        end
      end
      PH_MK_HI: begin
        marker_nxt     = {8'h00, b};
        marker_pos_nxt = byte_pos_r;
        phase_nxt      = PH_MK_LO;
      end
      PH_MK_LO: begin
        marker_nxt = code;
        if (code == MK_EOI) begin
          hit = 1'b1;
          st  = ST_END_IMAGE;
        end else begin
          phase_nxt = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        len_nxt   = {b, 8'h00};
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_nxt = len_full;
        if (len_full < MIN_LEN) begin
          hit = 1'b1;
          st  = ST_BAD_SEG;
        end else if (marker_r == MK_APP1) begin
          sig_idx_nxt   = 2'd0;
          sig_match_nxt = 1'b1;
          phase_nxt     = PH_SIG;
        end else if (skippable(marker_r)) begin
          skip_nxt  = len_full - MIN_LEN;
          phase_nxt = (len_full != MIN_LEN) ? PH_SKIP : PH_MK_HI;
        end else if (marker_r == MK_SOS) begin
          hit = 1'b1;
          st  = ST_END_IMAGE;
        end else begin
          hit = 1'b1;
          st  = ST_UNSUP;
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_r - 16'd1;
        if (skip_r == 16'd1) begin
          phase_nxt = PH_MK_HI;
        end
      end
      PH_SIG: begin
        sig_match_nxt = match;
        if (sig_idx_r == 2'd3) begin
          hit = 1'b1;
          st  = match ? ST_FOUND : ST_BAD_SEG;
        end else begin
          sig_idx_nxt = sig_idx_r + 2'd1;
        end
      end
      default: begin
      end
    endcase

    if (hit) begin
      res_valid  = accept;
      res.status = st;
      if (st == ST_FOUND) begin
        res.segment_offset = marker_pos_r;
        res.segment_size   = {1'b0, len_r} + 17'd2;
      end
      phase_nxt = PH_DONE;
    end else if (item.last_byte && phase_r != PH_DONE) begin
      res_valid  = accept;
      res.status = ST_TRUNCATED;
    end

    if (item.last_byte) begin
      phase_nxt      = PH_SOI_HI;
      marker_nxt     = '0;
      len_nxt        = '0;
      skip_nxt       = '0;
      sig_idx_nxt    = '0;
      sig_match_nxt  = 1'b1;
      byte_pos_nxt   = '0;
      marker_pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SOI_HI;
      marker_r     <= '0;
      len_r        <= '0;
      skip_r       <= '0;
      sig_idx_r    <= '0;
      sig_match_r  <= 1'b1;
      byte_pos_r   <= '0;
      marker_pos_r <= '0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      marker_r     <= marker_nxt;
      len_r        <= len_nxt;
      skip_r       <= skip_nxt;
      sig_idx_r    <= sig_idx_nxt;
      sig_match_r  <= sig_match_nxt;
      byte_pos_r   <= byte_pos_nxt;
      marker_pos_r <= marker_pos_nxt;
    end
  end

endmodule

### rtl/jpeg_exif_segment_locator.sv
// Top level of the JPEG Exif segment locator: parser plus the result register.
// Depends on jesl_pkg and jesl_parser.
//
// The input channel (in_valid, in_ready, in_data) carries one stream byte per
// transaction, with last_byte set on the final byte of an image. The output
// channel (out_valid, out_ready, out_data) carries at most one result per image:
// the Exif APP1 offset and size, or the reason the search ended.
// A result appears in the output register in the cycle after the byte that decides
// it is accepted. The block takes one byte every cycle while in_ready is high; its
// rate is set by the single parse state update per byte.
// A stalled result stays in the output register, and a new byte is still taken
// in the cycle that the result is taken. Only while a result waits and out_ready
// is low does in_ready drop.
// After the byte marked last the parse state returns to its reset values, so the
// next byte starts a new image. Reset clears the parse state and empties the
// output register.

module jpeg_exif_segment_locator
  import jesl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      accept;
  logic      res_valid;
  out_item_t res;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  jesl_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_data),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/jesl_checker.sv
// Port-level assertions for the JPEG Exif segment locator, bound to its top level.
// Depends on jesl_pkg and jpeg_exif_segment_locator.

module jesl_checker
  import jesl_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result transaction changed or dropped.");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("Result present right after reset.");

  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_FOUND |->
      out_data.segment_offset == 32'd0 && out_data.segment_size == 17'd0)
    else $error("Offset or size set on a result other than found.");

  a_size_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FOUND |-> out_data.segment_size >= 17'd4)
    else $error("Found result with a segment size below four.");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("Byte taken while a stalled result waits.");

endmodule

bind jpeg_exif_segment_locator jesl_checker u_jesl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
